FILE: src/clr_pkg.sv
// shared types, constants and helpers of the clipped line rasterizer
package clr_pkg;

  // parameter defaults
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned ColorBitsDef = 8;

  // fixed field widths
  localparam int unsigned CoordW     = 16;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned ErrW       = 20;
  localparam int unsigned QueueDepth = 2;

  // register indexes of the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CLIP_LEFT    = 3'd2,
    REG_CLIP_TOP     = 3'd3,
    REG_CLIP_RIGHT   = 3'd4,
    REG_CLIP_BOTTOM  = 3'd5,
    REG_LINE_COLOR   = 3'd6
  } reg_idx_e;

  typedef enum logic {
    ACT_DRAW = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic {
    STATUS_DONE    = 1'b0,
    STATUS_OUTSIDE = 1'b1
  } status_e;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_OUTSIDE,
    CMD_READ,
    CMD_LINE
  } cmd_kind_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   wcoord_t;

  typedef struct packed {
    cmd_kind_e kind;
    coord_t    x1;
    coord_t    y1;
    coord_t    x2;
    coord_t    y2;
  } cmd_t;

  // effective frame size and clip rectangle with right and bottom edges clamped
  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
    logic [CfgW-1:0] clip_l;
    logic [CfgW-1:0] clip_t;
    logic [CfgW-1:0] clip_r;
    logic [CfgW-1:0] clip_b;
  } geom_t;

  // unsigned register value widened to a signed coordinate
  function automatic wcoord_t ext_u(input logic [CfgW-1:0] v);
    return wcoord_t'({{(CoordW + 1 - CfgW){1'b0}}, v});
  endfunction

  // signed coordinate widened by one bit
  function automatic wcoord_t ext_s(input coord_t c);
    return wcoord_t'(c);
  endfunction

endpackage

FILE: src/clr_if.sv
// channel interfaces: draw/read items, results and configuration writes
interface clr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [clr_pkg::CoordW-1:0]   start_x;
  logic signed [clr_pkg::CoordW-1:0]   start_y;
  logic signed [clr_pkg::CoordW-1:0]   end_x;
  logic signed [clr_pkg::CoordW-1:0]   end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [clr_pkg::ColorW-1:0]   read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface

interface clr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [clr_pkg::CfgAddrW-1:0] addr;
  logic [clr_pkg::CfgW-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: src/clr_ram.sv
// generic single-write, single-read memory with registered read data
module clr_ram #(
  parameter int unsigned WIDTH = clr_pkg::ColorBitsDef,
  parameter int unsigned DEPTH = clr_pkg::MaxWidthDef * clr_pkg::MaxHeightDef
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/clr_front.sv
// front end: takes items, clamps axis lines to the clip span, classifies the work
module clr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  clr_in_if.sink          in_i,
  input  logic            accept_en_i,
  input  clr_pkg::geom_t  geom_i,
  output logic            cmd_vld_o,
  output clr_pkg::cmd_t   cmd_o,
  input  logic            cmd_rdy_i
);

  localparam int unsigned CoordW = clr_pkg::CoordW;

  logic              hold_vld_q, hold_vld_d;
  logic              hold_act_q;
  clr_pkg::coord_t   hold_x1_q, hold_y1_q, hold_x2_q, hold_y2_q;
  logic              accept;

  clr_pkg::wcoord_t  x1e, y1e, x2e, y2e;
  clr_pkg::wcoord_t  cle, cte, cre, cbe, we, he, crm1, cbm1;
  clr_pkg::wcoord_t  lo, hi, s, e;
  logic              clip_empty;

  // one holding stage in front of the classifier
  assign in_i.ready = accept_en_i & (~hold_vld_q | cmd_rdy_i);
  assign accept     = in_i.valid & in_i.ready;
  assign cmd_vld_o  = hold_vld_q;

  always_comb begin
    hold_vld_d = hold_vld_q;
    if (accept) begin
      hold_vld_d = 1'b1;
    end else if (cmd_rdy_i) begin
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_act_q <= in_i.action;
      hold_x1_q  <= in_i.start_x;
      hold_y1_q  <= in_i.start_y;
      hold_x2_q  <= in_i.end_x;
      hold_y2_q  <= in_i.end_y;
    end
  end

  // classify the held item
  always_comb begin
    x1e  = clr_pkg::ext_s(hold_x1_q);
    y1e  = clr_pkg::ext_s(hold_y1_q);
    x2e  = clr_pkg::ext_s(hold_x2_q);
    y2e  = clr_pkg::ext_s(hold_y2_q);
    cle  = clr_pkg::ext_u(geom_i.clip_l);
    cte  = clr_pkg::ext_u(geom_i.clip_t);
    cre  = clr_pkg::ext_u(geom_i.clip_r);
    cbe  = clr_pkg::ext_u(geom_i.clip_b);
    we   = clr_pkg::ext_u(geom_i.width);
    he   = clr_pkg::ext_u(geom_i.height);
    crm1 = cre - clr_pkg::wcoord_t'(1);
    cbm1 = cbe - clr_pkg::wcoord_t'(1);
    clip_empty = (geom_i.clip_l >= geom_i.clip_r) || (geom_i.clip_t >= geom_i.clip_b);

    lo = '0;
    hi = '0;
    s  = '0;
    e  = '0;

    cmd_o.kind = clr_pkg::CMD_NONE;
    cmd_o.x1   = hold_x1_q;
    cmd_o.y1   = hold_y1_q;
    cmd_o.x2   = hold_x2_q;
    cmd_o.y2   = hold_y2_q;

    if (hold_act_q == clr_pkg::ACT_READ) begin
      if (!x1e[CoordW] && (x1e < we) && !y1e[CoordW] && (y1e < he)) begin
        cmd_o.kind = clr_pkg::CMD_READ;
      end else begin
        cmd_o.kind = clr_pkg::CMD_OUTSIDE;
      end
    end else if (clip_empty) begin
      cmd_o.kind = clr_pkg::CMD_NONE;
    end else if (hold_y1_q == hold_y2_q) begin
      // horizontal line or single point: walk only the clipped span
      lo = (x1e < x2e) ? x1e : x2e;
      hi = (x1e < x2e) ? x2e : x1e;
      s  = (lo < cle) ? cle : lo;
      e  = (hi > crm1) ? crm1 : hi;
      if ((y1e >= cte) && (y1e < cbe) && (s <= e)) begin
        cmd_o.kind = clr_pkg::CMD_LINE;
        cmd_o.x1   = clr_pkg::coord_t'(s[CoordW-1:0]);
        cmd_o.x2   = clr_pkg::coord_t'(e[CoordW-1:0]);
      end
    end else if (hold_x1_q == hold_x2_q) begin
      // vertical line: walk only the clipped span
      lo = (y1e < y2e) ? y1e : y2e;
      hi = (y1e < y2e) ? y2e : y1e;
      s  = (lo < cte) ? cte : lo;
      e  = (hi > cbm1) ? cbm1 : hi;
      if ((x1e >= cle) && (x1e < cre) && (s <= e)) begin
        cmd_o.kind = clr_pkg::CMD_LINE;
        cmd_o.y1   = clr_pkg::coord_t'(s[CoordW-1:0]);
        cmd_o.y2   = clr_pkg::coord_t'(e[CoordW-1:0]);
      end
    end else begin
      cmd_o.kind = clr_pkg::CMD_LINE;
    end
  end

endmodule

FILE: src/clr_queue.sv
// short command queue between front and back end
module clr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_vld_i,
  input  clr_pkg::cmd_t  push_data_i,
  output logic           push_rdy_o,
  output logic           pop_vld_o,
  output clr_pkg::cmd_t  pop_data_o,
  input  logic           pop_i
);

  localparam int unsigned Depth = clr_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  clr_pkg::cmd_t   entries [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_rdy_o = (cnt_q != CntW'(Depth));
  assign pop_vld_o  = (cnt_q != '0);
  assign pop_data_o = entries[rd_ptr_q];
  assign push       = push_vld_i & push_rdy_o;
  assign pop        = pop_i & pop_vld_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/clr_back.sv
// back end: clears the frame store, walks lines, reads pixels, returns results
module clr_back #(
  parameter int unsigned MAX_WIDTH  = clr_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = clr_pkg::MaxHeightDef,
  parameter int unsigned COLOR_BITS = clr_pkg::ColorBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_vld_i,
  input  clr_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  clr_pkg::geom_t                geom_i,
  input  logic [clr_pkg::ColorW-1:0]    line_color_i,
  output logic                          busy_o,
  clr_out_if.source                     res_o
);

  localparam int unsigned CfgW   = clr_pkg::CfgW;
  localparam int unsigned ColorW = clr_pkg::ColorW;
  localparam int unsigned ErrW   = clr_pkg::ErrW;
  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned MulW   = YW + CfgW;
  localparam int unsigned LinW0  = (MulW > XW) ? MulW : XW;
  localparam int unsigned LinW   = ((LinW0 > AW) ? LinW0 : AW) + 1;
  localparam logic signed [ErrW-1:0] ErrZero = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_READ
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              res_vld_q, res_vld_d;
  logic              res_status_q, res_status_d;
  logic [ColorW-1:0] res_data_q, res_data_d;

  // walker registers
  clr_pkg::coord_t        x_q, x_d, y_q, y_d, x2_q, x2_d, y2_q, y2_d;
  logic signed [ErrW-1:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic                   sxn_q, sxn_d, syn_q, syn_d;

  // pixel address pipeline
  logic              a_vld_q, a_vld_d, a_rd_q, a_rd_d;
  logic [XW-1:0]     a_x_q, a_x_d;
  logic [YW-1:0]     a_y_q, a_y_d;
  logic              b_vld_q, b_rd_q;
  logic [AW-1:0]     b_addr_q, b_addr_d;
  logic              c_rd_q;

  logic [MulW-1:0]        mul;
  logic [LinW-1:0]        lin;
  clr_pkg::wcoord_t       xe, ye, sx1, sy1, sx2, sy2, dxw, dyw;
  logic signed [ErrW-1:0] e2;
  logic                   step_x, step_y, at_end, in_clip;

  logic                   clearing;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COLOR_BITS-1:0]  ram_wdata, ram_rdata;

  assign busy_o          = (state_q == ST_CLEAR);
  assign clearing        = (state_q == ST_CLEAR);
  assign res_o.valid     = res_vld_q;
  assign res_o.status    = res_status_q;
  assign res_o.read_data = res_data_q;

  // linear address of the pixel in stage a
  always_comb begin
    mul      = MulW'(a_y_q) * MulW'(geom_i.width);
    lin      = LinW'(mul) + LinW'(a_x_q);
    b_addr_d = lin[AW-1:0];
  end

  // sequencer and bresenham step
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    res_vld_d    = res_vld_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    x_d   = x_q;
    y_d   = y_q;
    x2_d  = x2_q;
    y2_d  = y2_q;
    dx_d  = dx_q;
    dy_d  = dy_q;
    err_d = err_q;
    sxn_d = sxn_q;
    syn_d = syn_q;
    a_vld_d   = 1'b0;
    a_rd_d    = 1'b0;
    a_x_d     = a_x_q;
    a_y_d     = a_y_q;
    cmd_pop_o = 1'b0;

    if (res_vld_q && res_o.ready) begin
      res_vld_d = 1'b0;
    end

    // current walk position
    xe      = clr_pkg::ext_s(x_q);
    ye      = clr_pkg::ext_s(y_q);
    in_clip = (xe >= clr_pkg::ext_u(geom_i.clip_l)) && (xe < clr_pkg::ext_u(geom_i.clip_r)) &&
              (ye >= clr_pkg::ext_u(geom_i.clip_t)) && (ye < clr_pkg::ext_u(geom_i.clip_b));
    at_end  = (x_q == x2_q) && (y_q == y2_q);
    e2      = err_q <<< 1;
    step_x  = (e2 >= dy_q);
    step_y  = (e2 <= dx_q);

    // deltas of the line at the queue head
    sx1 = clr_pkg::ext_s(cmd_i.x1);
    sy1 = clr_pkg::ext_s(cmd_i.y1);
    sx2 = clr_pkg::ext_s(cmd_i.x2);
    sy2 = clr_pkg::ext_s(cmd_i.y2);
    dxw = (sx2 > sx1) ? sx2 - sx1 : sx1 - sx2;
    dyw = (sy2 > sy1) ? sy2 - sy1 : sy1 - sy2;

    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_vld_i && !res_vld_q) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            clr_pkg::CMD_NONE: begin
              res_vld_d    = 1'b1;
              res_status_d = clr_pkg::STATUS_DONE;
              res_data_d   = '0;
            end
            clr_pkg::CMD_OUTSIDE: begin
              res_vld_d    = 1'b1;
              res_status_d = clr_pkg::STATUS_OUTSIDE;
              res_data_d   = '0;
            end
            clr_pkg::CMD_READ: begin
              a_vld_d = 1'b1;
              a_rd_d  = 1'b1;
              a_x_d   = cmd_i.x1[XW-1:0];
              a_y_d   = cmd_i.y1[YW-1:0];
              state_d = ST_READ;
            end
            clr_pkg::CMD_LINE: begin
              x_d     = cmd_i.x1;
              y_d     = cmd_i.y1;
              x2_d    = cmd_i.x2;
              y2_d    = cmd_i.y2;
              dx_d    = ErrW'(dxw);
              dy_d    = -ErrW'(dyw);
              sxn_d   = !(sx1 < sx2);
              syn_d   = !(sy1 < sy2);
              state_d = ST_SETUP;
            end
          endcase
        end
      end
      ST_SETUP: begin
        err_d   = dx_q + dy_q;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        // one pixel per cycle into the address pipeline
        a_vld_d = in_clip;
        a_x_d   = x_q[XW-1:0];
        a_y_d   = y_q[YW-1:0];
        if (at_end) begin
          res_vld_d    = 1'b1;
          res_status_d = clr_pkg::STATUS_DONE;
          res_data_d   = '0;
          state_d      = ST_IDLE;
        end else begin
          err_d = err_q + (step_x ? dy_q : ErrZero) + (step_y ? dx_q : ErrZero);
          if (step_x) begin
            x_d = x_q + (sxn_q ? -clr_pkg::coord_t'(1) : clr_pkg::coord_t'(1));
          end
          if (step_y) begin
            y_d = y_q + (syn_q ? -clr_pkg::coord_t'(1) : clr_pkg::coord_t'(1));
          end
        end
      end
      ST_READ: begin
        if (c_rd_q) begin
          res_vld_d    = 1'b1;
          res_status_d = clr_pkg::STATUS_DONE;
          res_data_d   = ColorW'(ram_rdata);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, result register and pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      res_vld_q    <= 1'b0;
      res_status_q <= 1'b0;
      res_data_q   <= '0;
      a_vld_q      <= 1'b0;
      a_rd_q       <= 1'b0;
      b_vld_q      <= 1'b0;
      b_rd_q       <= 1'b0;
      c_rd_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      res_vld_q    <= res_vld_d;
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
      a_vld_q      <= a_vld_d;
      a_rd_q       <= a_rd_d;
      b_vld_q      <= a_vld_q;
      b_rd_q       <= a_rd_q;
      c_rd_q       <= b_vld_q & b_rd_q;
    end
  end

  // walker and address datapath
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    x2_q     <= x2_d;
    y2_q     <= y2_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    err_q    <= err_d;
    sxn_q    <= sxn_d;
    syn_q    <= syn_d;
    a_x_q    <= a_x_d;
    a_y_q    <= a_y_d;
    b_addr_q <= b_addr_d;
  end

  // frame store port: clearing sweep or pixel writes
  assign ram_we    = clearing | (b_vld_q & ~b_rd_q);
  assign ram_waddr = clearing ? clr_cnt_q : b_addr_q;
  assign ram_wdata = clearing ? '0 : COLOR_BITS'(line_color_i);

  clr_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (Depth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (b_addr_q),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: src/clipped_line_rasterizer.sv
// top level of the clipped line rasterizer: configuration registers and channel wiring
//
// Line engine with a private frame store of MAX_WIDTH*MAX_HEIGHT pixels. After reset
// the store is swept to zero one pixel per cycle, and no item is taken until the
// sweep ends; configuration writes are taken at all times. A front end holds and
// classifies each item and hands it through a two-entry queue to the back end, so
// items keep arriving while the back end works or a result waits. The back end
// handles one item at a time: a draw walks one Bresenham step per cycle in the
// error-term update loop; horizontal and vertical lines are first cut to their
// clipped span, so only that span is walked. A read passes the address multiply
// stage and the registered memory read. Rejected or fully clipped items are answered
// without a walk. Each item gives exactly one result transfer.
module clipped_line_rasterizer #(
  parameter int unsigned MAX_WIDTH  = clr_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = clr_pkg::MaxHeightDef,
  parameter int unsigned COLOR_BITS = clr_pkg::ColorBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clr_in_if.sink    in_i,
  clr_out_if.source res_o,
  clr_cfg_if.sink   cfg_i
);

  localparam int unsigned CfgW   = clr_pkg::CfgW;
  localparam int unsigned ColorW = clr_pkg::ColorW;

  logic [CfgW-1:0]   frame_width_q, frame_height_q;
  logic [CfgW-1:0]   clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [ColorW-1:0] line_color_q;

  clr_pkg::geom_t geom;
  clr_pkg::cmd_t  front_cmd, queue_cmd;
  logic           front_vld, queue_rdy, queue_vld, queue_pop, back_busy;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(256);
      frame_height_q <= CfgW'(256);
      clip_left_q    <= '0;
      clip_top_q     <= '0;
      clip_right_q   <= CfgW'(256);
      clip_bottom_q  <= CfgW'(256);
      line_color_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (clr_pkg::reg_idx_e'(cfg_i.addr))
        clr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data;
        clr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data;
        clr_pkg::REG_CLIP_LEFT:    clip_left_q    <= cfg_i.data;
        clr_pkg::REG_CLIP_TOP:     clip_top_q     <= cfg_i.data;
        clr_pkg::REG_CLIP_RIGHT:   clip_right_q   <= cfg_i.data;
        clr_pkg::REG_CLIP_BOTTOM:  clip_bottom_q  <= cfg_i.data;
        clr_pkg::REG_LINE_COLOR:   line_color_q   <= cfg_i.data[ColorW-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective frame size and clip rectangle, right and bottom edges clamped to it
  always_comb begin
    geom.width  = (int'(frame_width_q) > MAX_WIDTH) ? CfgW'(MAX_WIDTH) : frame_width_q;
    geom.height = (int'(frame_height_q) > MAX_HEIGHT) ? CfgW'(MAX_HEIGHT) : frame_height_q;
    geom.clip_l = clip_left_q;
    geom.clip_t = clip_top_q;
    geom.clip_r = (clip_right_q > geom.width) ? geom.width : clip_right_q;
    geom.clip_b = (clip_bottom_q > geom.height) ? geom.height : clip_bottom_q;
  end

  clr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .accept_en_i (~back_busy),
    .geom_i      (geom),
    .cmd_vld_o   (front_vld),
    .cmd_o       (front_cmd),
    .cmd_rdy_i   (queue_rdy)
  );

  clr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (front_vld),
    .push_data_i (front_cmd),
    .push_rdy_o  (queue_rdy),
    .pop_vld_o   (queue_vld),
    .pop_data_o  (queue_cmd),
    .pop_i       (queue_pop)
  );

  clr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_vld_i    (queue_vld),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .geom_i       (geom),
    .line_color_i (line_color_q),
    .busy_o       (back_busy),
    .res_o        (res_o)
  );

endmodule

FILE: verif/tb_clipped_line_rasterizer.sv
// self-checking testbench of the clipped line rasterizer: line draws, pixel reads, register setups
module tb_clipped_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import clr_pkg::*;

  localparam longint MaxW = 256;
  localparam longint MaxH = 256;
  localparam int unsigned StoreSize = 65536;
  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;
  localparam int unsigned PhaseCount = 15;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PrintLimit = 30;
  // clearing sweep, a handful of full-range lines and every frame-sized line waiting
  // out the longest gap and stall, taken several times
  localparam longint unsigned CycleLimit = 8_000_000;

  typedef struct packed {
    action_e act;
    coord_t  sx;
    coord_t  sy;
    coord_t  ex;
    coord_t  ey;
  } pix_item_t;

  typedef struct packed {
    status_e           status;
    logic [ColorW-1:0] data;
  } pix_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgAddrW-1:0]  idx;
    logic [CfgW-1:0]      value;
    action_e              act;
    int                   sx;
    int                   sy;
    int                   ex;
    int                   ey;
    bit                   typed;
    status_e              status;
    int                   data;
  } opening_row_t;

  logic clk;
  logic rst_n;

  clr_in_if  in_bus ();
  clr_out_if res_bus ();
  clr_cfg_if cfg_bus ();

  clipped_line_rasterizer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // shadow of the frame store and the registers
  logic [ColorW-1:0] pixels [StoreSize];
  logic [CfgW-1:0]   frame_w, frame_h, clip_l, clip_t, clip_r, clip_b;
  logic [ColorW-1:0] ink;

  pix_result_t pending_results [$];

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int unsigned fail_count = 0;
  int unsigned checked_count = 0;
  int unsigned draw_count = 0;
  int unsigned read_count = 0;
  int unsigned write_count = 0;
  longint unsigned cycle_count = 0;

  // directed opening: extremes, both actions, clip and frame corner cases
  opening_row_t opening_rows [] = '{
    '{ROW_ITEM, '0, '0, ACT_READ, 0, 0, 0, 0, 1'b1, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 255, 255, 0, 0, 1'b1, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 256, 0, 0, 0, 1'b1, STATUS_OUTSIDE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 0, -1, 0, 0, 1'b1, STATUS_OUTSIDE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, -32768, 32767, -1, -1, 1'b1, STATUS_OUTSIDE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 32767, -32768, 0, 0, 1'b1, STATUS_OUTSIDE, 0},
    '{ROW_CFG, REG_LINE_COLOR, 9'h1A5, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 0, 0, 255, 255, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 17, 17, 0, 0, 1'b1, STATUS_DONE, 8'hA5},
    '{ROW_ITEM, '0, '0, ACT_DRAW, -32768, 3, 32767, 3, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 9, 32767, 9, -32768, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, -32768, -32768, 32767, 32767, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 300, -40, -60, 200, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 128, 64, 128, 64, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 128, 64, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, RegUnused, 9'h1FF, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, REG_FRAME_WIDTH, 9'd0, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 0, 0, 0, 0, 1'b1, STATUS_OUTSIDE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 0, 0, 20, 5, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, REG_FRAME_WIDTH, 9'd511, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, REG_FRAME_HEIGHT, 9'd1, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 200, 1, 0, 0, 1'b1, STATUS_OUTSIDE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 3, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, REG_CLIP_LEFT, 9'h1FF, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 0, 0, 255, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, REG_CLIP_LEFT, 9'd5, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_CFG, REG_CLIP_RIGHT, 9'd9, ACT_DRAW, 0, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_DRAW, 0, 0, 255, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 4, 0, 0, 0, 1'b0, STATUS_DONE, 0},
    '{ROW_ITEM, '0, '0, ACT_READ, 8, 0, 0, 0, 1'b0, STATUS_DONE, 0}
  };

  // register value limited to a maximum
  function automatic longint used_dim(logic [CfgW-1:0] v, longint cap);
    return (longint'(v) > cap) ? cap : longint'(v);
  endfunction

  // register write as the block sees it
  function automatic void shadow_write(logic [CfgAddrW-1:0] idx, logic [CfgW-1:0] val);
    case (idx)
      REG_FRAME_WIDTH:  frame_w = val;
      REG_FRAME_HEIGHT: frame_h = val;
      REG_CLIP_LEFT:    clip_l = val;
      REG_CLIP_TOP:     clip_t = val;
      REG_CLIP_RIGHT:   clip_r = val;
      REG_CLIP_BOTTOM:  clip_b = val;
      REG_LINE_COLOR:   ink = val[ColorW-1:0];
      default: ;
    endcase
  endfunction

  // draw into the shadow store or read from it, giving the expected result
  function automatic pix_result_t predict_result(pix_item_t it);
    longint w, h, l, t, r, b, x1, y1, x2, y2;
    longint dx, dy, sx, sy, err, e2, x, y, lo, hi;
    pix_result_t res;
    w = used_dim(frame_w, MaxW);
    h = used_dim(frame_h, MaxH);
    l = longint'(clip_l);
    t = longint'(clip_t);
    r = used_dim(clip_r, w);
    b = used_dim(clip_b, h);
    x1 = $signed(it.sx);
    y1 = $signed(it.sy);
    x2 = $signed(it.ex);
    y2 = $signed(it.ey);
    res.status = STATUS_DONE;
    res.data = '0;
    if (it.act == ACT_READ) begin
      if (x1 < 0 || x1 >= w || y1 < 0 || y1 >= h) res.status = STATUS_OUTSIDE;
      else res.data = pixels[y1 * w + x1];
    end else if (l < r && t < b) begin
      if (y1 == y2) begin
        // flat line: only the clipped span is written
        if (y1 >= t && y1 < b) begin
          lo = (x1 < x2) ? x1 : x2;
          hi = (x1 < x2) ? x2 : x1;
          if (lo < l) lo = l;
          if (hi > r - 1) hi = r - 1;
          for (x = lo; x <= hi; x++) pixels[y1 * w + x] = ink;
        end
      end else if (x1 == x2) begin
        // upright line: same idea along the rows
        if (x1 >= l && x1 < r) begin
          lo = (y1 < y2) ? y1 : y2;
          hi = (y1 < y2) ? y2 : y1;
          if (lo < t) lo = t;
          if (hi > b - 1) hi = b - 1;
          for (y = lo; y <= hi; y++) pixels[y * w + x1] = ink;
        end
      end else begin
        // error-term walk from the first endpoint to the second
        dx = (x2 > x1) ? x2 - x1 : x1 - x2;
        dy = (y2 > y1) ? y1 - y2 : y2 - y1;
        sx = (x1 < x2) ? 1 : -1;
        sy = (y1 < y2) ? 1 : -1;
        err = dx + dy;
        x = x1;
        y = y1;
        forever begin
          if (x >= l && x < r && y >= t && y < b) pixels[y * w + x] = ink;
          if (x == x2 && y == y2) break;
          e2 = 2 * err;
          if (e2 >= dy) begin
            err += dy;
            x += sx;
          end
          if (e2 <= dx) begin
            err += dx;
            y += sy;
          end
        end
      end
    end
    return res;
  endfunction

  // idle length, mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_count < PrintLimit)
      $display("%0t mismatch on %0s: got %0h, want %0h (result %0d)",
               $realtime, what, got, want, checked_count);
    fail_count++;
  endtask

  // one item transfer; the expectation is taken when the item is accepted
  task automatic push_item(pix_item_t it, bit typed, pix_result_t fixed);
    int unsigned gap;
    pix_result_t res;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= it.act;
    in_bus.start_x <= it.sx;
    in_bus.start_y <= it.sy;
    in_bus.end_x   <= it.ex;
    in_bus.end_y   <= it.ey;
    forever begin
      @(posedge clk);
      if (in_bus.ready) break;
    end
    res = predict_result(it);
    pending_results.push_back(typed ? fixed : res);
    if (it.act == ACT_READ) read_count++;
    else draw_count++;
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_bus.ready) break;
    end
    shadow_write(idx, val);
    write_count++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run limit of %0d cycles reached with %0d results pending",
               CycleLimit, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = stalls_on ? pick_gap() : 0;
      if (stall == 0) res_bus.ready <= 1'b1;
      else begin
        res_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", res_bus.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.status !== want.status)
          report_mismatch("status", res_bus.status, want.status);
        if (res_bus.read_data !== want.data)
          report_mismatch("read_data", res_bus.read_data, want.data);
      end
      checked_count++;
    end
  end

  // stimulus
  initial begin
    pix_item_t it;
    pix_result_t fixed;
    logic [CfgW-1:0] cfg_vals [7];
    longint w, h, ax, ay, bx, by, px, py;
    int unsigned roll, pick;

    in_bus.valid   = 1'b0;
    in_bus.action  = ACT_DRAW;
    in_bus.start_x = '0;
    in_bus.start_y = '0;
    in_bus.end_x   = '0;
    in_bus.end_y   = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.addr   = '0;
    cfg_bus.data   = '0;
    rst_n = 1'b0;
    foreach (pixels[i]) pixels[i] = '0;
    frame_w = 9'd256;
    frame_h = 9'd256;
    clip_l = '0;
    clip_t = '0;
    clip_r = 9'd256;
    clip_b = 9'd256;
    ink = '0;
    ax = 0;
    ay = 0;
    bx = 0;
    by = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(opening_rows[i].idx, opening_rows[i].value);
      end else begin
        it.act = opening_rows[i].act;
        it.sx = coord_t'(opening_rows[i].sx);
        it.sy = coord_t'(opening_rows[i].sy);
        it.ex = coord_t'(opening_rows[i].ex);
        it.ey = coord_t'(opening_rows[i].ey);
        fixed.status = opening_rows[i].status;
        fixed.data = ColorW'(opening_rows[i].data);
        push_item(it, opening_rows[i].typed, fixed);
      end
    end

    // random phases, each under a fresh register setup
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      gaps_on = (p % 4 != 1);
      stalls_on = (p % 4 != 2);
      case ($urandom_range(0, 7))
        0: cfg_vals[REG_FRAME_WIDTH] = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'd1;
        1: cfg_vals[REG_FRAME_WIDTH] = 9'd256;
        2: cfg_vals[REG_FRAME_WIDTH] = CfgW'($urandom_range(257, 511));
        default: cfg_vals[REG_FRAME_WIDTH] = CfgW'($urandom_range(2, 255));
      endcase
      case ($urandom_range(0, 7))
        0: cfg_vals[REG_FRAME_HEIGHT] = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'd1;
        1: cfg_vals[REG_FRAME_HEIGHT] = 9'd256;
        2: cfg_vals[REG_FRAME_HEIGHT] = CfgW'($urandom_range(257, 511));
        default: cfg_vals[REG_FRAME_HEIGHT] = CfgW'($urandom_range(2, 255));
      endcase
      w = used_dim(cfg_vals[REG_FRAME_WIDTH], MaxW);
      h = used_dim(cfg_vals[REG_FRAME_HEIGHT], MaxH);
      cfg_vals[REG_CLIP_LEFT] = ($urandom_range(0, 4) == 0) ?
                                CfgW'($urandom_range(0, 511)) : CfgW'($urandom_range(0, 12));
      cfg_vals[REG_CLIP_TOP] = ($urandom_range(0, 4) == 0) ?
                               CfgW'($urandom_range(0, 511)) : CfgW'($urandom_range(0, 12));
      case ($urandom_range(0, 3))
        0: cfg_vals[REG_CLIP_RIGHT] = 9'd511;
        1: cfg_vals[REG_CLIP_RIGHT] = CfgW'($urandom_range(0, 511));
        default: cfg_vals[REG_CLIP_RIGHT] = CfgW'((w > 12) ? w - $urandom_range(0, 12) : w);
      endcase
      case ($urandom_range(0, 3))
        0: cfg_vals[REG_CLIP_BOTTOM] = 9'd511;
        1: cfg_vals[REG_CLIP_BOTTOM] = CfgW'($urandom_range(0, 511));
        default: cfg_vals[REG_CLIP_BOTTOM] = CfgW'((h > 12) ? h - $urandom_range(0, 12) : h);
      endcase
      // upper bit of the color write is dropped by the block
      case ($urandom_range(0, 4))
        0: cfg_vals[REG_LINE_COLOR] = 9'd0;
        1: cfg_vals[REG_LINE_COLOR] = 9'd255;
        2: cfg_vals[REG_LINE_COLOR] = CfgW'($urandom_range(256, 511));
        default: cfg_vals[REG_LINE_COLOR] = CfgW'($urandom_range(1, 254));
      endcase
      for (int r = 0; r < 7; r++) write_reg(CfgAddrW'(r), cfg_vals[r]);
      if ($urandom_range(0, 2) == 0) write_reg(RegUnused, CfgW'($urandom));

      if (w == 0) w = 1;
      if (h == 0) h = 1;
      for (int n = 0; n < PhaseItems; n++) begin
        // now and then hold off until the block has drained
        if ($urandom_range(0, 49) == 0) settle();
        it.act = ACT_DRAW;
        it.sx = coord_t'($urandom);
        it.sy = coord_t'($urandom);
        it.ex = coord_t'($urandom);
        it.ey = coord_t'($urandom);
        roll = $urandom_range(0, 199);
        if (roll < 70) begin
          it.act = ACT_READ;
          pick = $urandom_range(0, 9);
          if (pick >= 4) begin
            it.sx = coord_t'(int'($urandom_range(0, w + 3)) - 2);
            it.sy = coord_t'(int'($urandom_range(0, h + 3)) - 2);
          end else if (pick >= 1) begin
            // look at a pixel near the last line drawn
            case ($urandom_range(0, 2))
              0: begin px = ax; py = ay; end
              1: begin px = bx; py = by; end
              default: begin px = (ax + bx) / 2; py = (ay + by) / 2; end
            endcase
            it.sx = coord_t'(px + int'($urandom_range(0, 2)) - 1);
            it.sy = coord_t'(py + int'($urandom_range(0, 2)) - 1);
          end
        end else if (roll < 80) begin
          // flat or upright line with endpoints anywhere
          if ($urandom_range(0, 1) == 0) begin
            it.sy = coord_t'(int'($urandom_range(0, h + 1)) - 1);
            it.ey = it.sy;
          end else begin
            it.sx = coord_t'(int'($urandom_range(0, w + 1)) - 1);
            it.ex = it.sx;
          end
        end else if (roll > 80) begin
          it.sx = coord_t'(int'($urandom_range(0, w + 31)) - 16);
          it.sy = coord_t'(int'($urandom_range(0, h + 31)) - 16);
          it.ex = coord_t'(int'($urandom_range(0, w + 31)) - 16);
          it.ey = coord_t'(int'($urandom_range(0, h + 31)) - 16);
        end
        if (it.act == ACT_DRAW) begin
          ax = $signed(it.sx);
          ay = $signed(it.sy);
          bx = $signed(it.ex);
          by = $signed(it.ey);
        end
        push_item(it, 1'b0, '0);
      end
    end

    // drain and let any stray result show up
    settle();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d line draws and %0d pixel reads over %0d register writes",
             draw_count, read_count, write_count);
    $display("%0d results compared, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/clr_pkg.sv
src/clr_if.sv
src/clr_ram.sv
src/clr_front.sv
src/clr_queue.sv
src/clr_back.sv
src/clipped_line_rasterizer.sv
verif/tb_clipped_line_rasterizer.sv
